FILE: src/stpc_pkg.sv
package stpc_pkg;

  localparam int RAW_W      = 20;
  localparam int TRIM_W     = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int TEMP_W     = 15;
  localparam int FINE_W     = 25;
  localparam int WORD_W     = 64;
  localparam int DIV_DEN_W  = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TRIM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TRIM_C = 2'd3;

  localparam logic signed [19:0] TEMP_MIN    = -20'sd4000;
  localparam logic signed [19:0] TEMP_MAX    = 20'sd8500;
  localparam logic signed [25:0] FINE_OFFSET = 26'sd128000;
  localparam logic [20:0]        PRESS_BASE  = 21'h100000;
  localparam logic [11:0]        DIV_SCALE   = 12'd3125;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [31:0]       fine_temperature;
    logic [31:0]              pressure_pa_q24_8;
    logic                     divisor_zero;
  } out_t;

  // Side information that rides along with a quotient.
  typedef struct packed {
    logic                     neg;
    logic                     zero;
    logic signed [TEMP_W-1:0] tc;
    logic signed [FINE_W-1:0] fine;
  } tag_t;

endpackage

FILE: src/stpc_div.sv
module stpc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [stpc_pkg::WORD_W-1:0]      in_num,
  input  logic [stpc_pkg::DIV_DEN_W-1:0]   in_den,
  input  stpc_pkg::tag_t                   in_tag,
  output logic                             out_vld,
  output logic [stpc_pkg::WORD_W-1:0]      out_quo,
  output stpc_pkg::tag_t                   out_tag
);
  import stpc_pkg::*;

  localparam int STEPS = WORD_W;

  // Restoring divider, one quotient bit per stage. The numerator shifts out
  // of the top of nq while quotient bits shift in at the bottom.
  logic                 vld_r [1:STEPS];
  logic [WORD_W-1:0]    nq_r  [1:STEPS];
  logic [DIV_DEN_W-1:0] rem_r [1:STEPS];
  logic [DIV_DEN_W-1:0] den_r [1:STEPS];
  tag_t                 tag_r [1:STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                 vld_s;
    logic [WORD_W-1:0]    nq_s;
    logic [DIV_DEN_W-1:0] rem_s;
    logic [DIV_DEN_W-1:0] den_s;
    tag_t                 tag_s;
    logic [DIV_DEN_W:0]   rsh;
    logic [DIV_DEN_W+1:0] diff;

    if (k == 0) begin : g_first
      assign vld_s = in_vld;
      assign nq_s  = in_num;
      assign rem_s = '0;
      assign den_s = in_den;
      assign tag_s = in_tag;
    end else begin : g_next
      assign vld_s = vld_r[k];
      assign nq_s  = nq_r[k];
      assign rem_s = rem_r[k];
      assign den_s = den_r[k];
      assign tag_s = tag_r[k];
    end

    assign rsh  = {rem_s, nq_s[WORD_W-1]};
    assign diff = {1'b0, rsh} - {2'b00, den_s};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[k+1]  <= {nq_s[WORD_W-2:0], ~diff[DIV_DEN_W+1]};
        rem_r[k+1] <= diff[DIV_DEN_W+1] ? rsh[DIV_DEN_W-1:0] : diff[DIV_DEN_W-1:0];
        den_r[k+1] <= den_s;
        tag_r[k+1] <= tag_s;
      end
    end
  end

  assign out_vld = vld_r[STEPS];
  assign out_quo = nq_r[STEPS];
  assign out_tag = tag_r[STEPS];

endmodule

FILE: src/sensor_temp_pressure_compensate_top.sv
// Channel  Ports                              Direction
// input    in_valid, in_ready, in_data        raw pressure and temperature in
// result   out_valid, out_ready, out_data     compensated temperature and pressure out
// config   cfg_we, cfg_index, cfg_wdata       trim word writes, no read-back
//
// One transaction enters per cycle unless the pipeline holds. The pipeline is made of
// the 64-stage restoring divider for the pressure quotient, plus eight
// stages before it and six after it (including the output register).
// Synchronous active-low reset clears the valid bits and the trim registers.
// The whole pipeline holds while a result waits in the output register.
module sensor_temp_pressure_compensate_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  stpc_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output stpc_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [stpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stpc_pkg::TRIM_W-1:0]       cfg_wdata
);
  import stpc_pkg::*;

  logic [TRIM_W-1:0] temp_trim_r, press_a_r, press_b_r, press_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r <= '0;
      press_a_r   <= '0;
      press_b_r   <= '0;
      press_c_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP_TRIM:    temp_trim_r <= cfg_wdata;
        CFG_PRESS_TRIM_A: press_a_r   <= cfg_wdata;
        CFG_PRESS_TRIM_B: press_b_r   <= cfg_wdata;
        CFG_PRESS_TRIM_C: press_c_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = temp_trim_r[15:0];
  assign t2 = $signed(temp_trim_r[31:16]);
  assign t3 = $signed(temp_trim_r[47:32]);
  assign p1 = press_a_r[15:0];
  assign p2 = $signed(press_a_r[31:16]);
  assign p3 = $signed(press_a_r[47:32]);
  assign p4 = $signed(press_b_r[15:0]);
  assign p5 = $signed(press_b_r[31:16]);
  assign p6 = $signed(press_b_r[47:32]);
  assign p7 = $signed(press_c_r[15:0]);
  assign p8 = $signed(press_c_r[31:16]);
  assign p9 = $signed(press_c_r[47:32]);

  logic en;
  logic out_valid_r;
  out_t out_data_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: temperature differences and their first products.
  logic signed [17:0] ta_nxt, tb_nxt;
  logic signed [33:0] tb_sq;
  logic               s1_v_r;
  logic signed [33:0] at_r;
  logic [32:0]        bb_r;
  logic [RAW_W-1:0]   s1_adcp_r;

  assign ta_nxt = $signed({1'b0, in_data.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign tb_nxt = $signed({2'b00, in_data.raw_temperature[19:4]}) - $signed({2'b00, t1});
  assign tb_sq  = 34'(tb_nxt) * 34'(tb_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      at_r      <= 34'(ta_nxt) * 34'(t2);
      bb_r      <= tb_sq[32:0];
      s1_adcp_r <= in_data.raw_pressure;
    end
  end

  // Stage 2: scale and apply T3.
  logic               s2_v_r;
  logic signed [22:0] v1t_r;
  logic signed [37:0] bt3_r;
  logic [RAW_W-1:0]   s2_adcp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      v1t_r     <= at_r[33:11];
      bt3_r     <= 38'($signed({1'b0, bb_r[32:12]})) * 38'(t3);
      s2_adcp_r <= s1_adcp_r;
    end
  end

  // Stage 3: fine temperature.
  logic               s3_v_r;
  logic signed [FINE_W-1:0] fine_r;
  logic [RAW_W-1:0]   s3_adcp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      fine_r    <= FINE_W'(v1t_r) + FINE_W'($signed(bt3_r[37:14]));
      s3_adcp_r <= s2_adcp_r;
    end
  end

  // Stage 4: centidegrees and the first pressure products.
  logic signed [27:0] f5_nxt;
  logic signed [19:0] tcw_nxt;
  logic signed [TEMP_W-1:0] tc_nxt;
  logic signed [25:0] pv_nxt;
  logic               s4_v_r;
  logic signed [49:0] v1sq_r;
  logic signed [41:0] v1p5_r, v1p2_r;
  tag_t               s4_tag_r;
  logic [RAW_W-1:0]   s4_adcp_r;

  assign f5_nxt  = 28'(fine_r) + (28'(fine_r) <<< 2) + 28'sd128;
  assign tcw_nxt = f5_nxt[27:8];
  always_comb begin
    if (tcw_nxt < TEMP_MIN)      tc_nxt = TEMP_W'(TEMP_MIN);
    else if (tcw_nxt > TEMP_MAX) tc_nxt = TEMP_W'(TEMP_MAX);
    else                         tc_nxt = tcw_nxt[TEMP_W-1:0];
  end
  assign pv_nxt = 26'(fine_r) - FINE_OFFSET;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      v1sq_r         <= 50'(pv_nxt) * 50'(pv_nxt);
      v1p5_r         <= 42'(pv_nxt) * 42'(p5);
      v1p2_r         <= 42'(pv_nxt) * 42'(p2);
      s4_tag_r.neg   <= 1'b0;
      s4_tag_r.zero  <= 1'b0;
      s4_tag_r.tc    <= tc_nxt;
      s4_tag_r.fine  <= fine_r;
      s4_adcp_r      <= s3_adcp_r;
    end
  end

  // Stage 5: square terms times P6 and P3.
  logic               s5_v_r;
  logic signed [63:0] v2a_r, v1a_r;
  logic signed [41:0] s5_v1p5_r, s5_v1p2_r;
  tag_t               s5_tag_r;
  logic [RAW_W-1:0]   s5_adcp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (en) s5_v_r <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      v2a_r     <= 64'(v1sq_r) * 64'(p6);
      v1a_r     <= 64'(v1sq_r) * 64'(p3);
      s5_v1p5_r <= v1p5_r;
      s5_v1p2_r <= v1p2_r;
      s5_tag_r  <= s4_tag_r;
      s5_adcp_r <= s4_adcp_r;
    end
  end

  // Stage 6: sums for the numerator offset and the divisor.
  logic               s6_v_r;
  logic signed [63:0] v2_r, x_r;
  tag_t               s6_tag_r;
  logic [RAW_W-1:0]   s6_adcp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (en) s6_v_r <= s5_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      v2_r      <= v2a_r + (64'(s5_v1p5_r) <<< 17) + (64'(p4) <<< 35);
      x_r       <= (v1a_r >>> 8) + (64'(s5_v1p2_r) <<< 12) + 64'sh0000_8000_0000_0000;
      s6_tag_r  <= s5_tag_r;
      s6_adcp_r <= s5_adcp_r;
    end
  end

  // Stage 7: divisor and unscaled numerator.
  logic signed [63:0] y_nxt;
  logic [20:0]        pb_nxt;
  logic               s7_v_r;
  logic signed [DIV_DEN_W-1:0] d_r;
  logic [63:0]        nbase_r;
  tag_t               s7_tag_r;

  assign y_nxt  = x_r * 64'($signed({1'b0, p1}));
  assign pb_nxt = PRESS_BASE - 21'(s6_adcp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (en) s7_v_r <= s6_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_r      <= y_nxt[63:33];
      nbase_r  <= (64'(pb_nxt) << 31) - v2_r;
      s7_tag_r <= s6_tag_r;
    end
  end

  // Stage 8: scale the numerator, split off the signs for the divider.
  logic [63:0]          n_nxt;
  logic                 s8_v_r;
  logic [63:0]          mn_r;
  logic [DIV_DEN_W-1:0] md_r;
  tag_t                 s8_tag_r;

  assign n_nxt = nbase_r * 64'(DIV_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) s8_v_r <= 1'b0;
    else if (en) s8_v_r <= s7_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mn_r          <= n_nxt[63] ? (64'd0 - n_nxt) : n_nxt;
      md_r          <= d_r[DIV_DEN_W-1] ? (DIV_DEN_W'(0) - d_r) : d_r;
      s8_tag_r.neg  <= n_nxt[63] ^ d_r[DIV_DEN_W-1];
      s8_tag_r.zero <= (d_r == '0);
      s8_tag_r.tc   <= s7_tag_r.tc;
      s8_tag_r.fine <= s7_tag_r.fine;
    end
  end

  logic        dv_vld;
  logic [63:0] dv_quo;
  tag_t        dv_tag;

  stpc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s8_v_r),
    .in_num  (mn_r),
    .in_den  (md_r),
    .in_tag  (s8_tag_r),
    .out_vld (dv_vld),
    .out_quo (dv_quo),
    .out_tag (dv_tag)
  );

  // Q1: signed quotient, forced to zero for a zero divisor.
  logic [63:0] qs_nxt;
  logic        q1_v_r;
  logic [63:0] q1_p_r;
  tag_t        q1_tag_r;

  assign qs_nxt = dv_tag.neg ? (64'd0 - dv_quo) : dv_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) q1_v_r <= 1'b0;
    else if (en) q1_v_r <= dv_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q1_p_r   <= dv_tag.zero ? 64'd0 : qs_nxt;
      q1_tag_r <= dv_tag;
    end
  end

  // Q2: 32x16 partial products of (p>>13)*P9 and p*P8, each modulo 2^64.
  logic [63:0]        s_nxt;
  logic [31:0]        p9u, p8u;
  logic               q2_v_r;
  logic [63:0]        q2_p_r, q2_s_r;
  logic signed [48:0] sp9lo_r, pp8lo_r;
  logic [63:0]        sp9hi_w, pp8hi_w;
  logic [31:0]        sp9hi_r, pp8hi_r;
  tag_t               q2_tag_r;

  assign s_nxt   = $signed(q1_p_r) >>> 13;
  assign p9u     = 32'(p9);
  assign p8u     = 32'(p8);
  assign sp9hi_w = s_nxt[63:32] * p9u;
  assign pp8hi_w = q1_p_r[63:32] * p8u;

  always_ff @(posedge clk) begin
    if (!rst_n) q2_v_r <= 1'b0;
    else if (en) q2_v_r <= q1_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sp9lo_r  <= 49'($signed({1'b0, s_nxt[31:0]})) * 49'(p9);
      pp8lo_r  <= 49'($signed({1'b0, q1_p_r[31:0]})) * 49'(p8);
      sp9hi_r  <= sp9hi_w[31:0];
      pp8hi_r  <= pp8hi_w[31:0];
      q2_s_r   <= s_nxt;
      q2_p_r   <= q1_p_r;
      q2_tag_r <= q1_tag_r;
    end
  end

  // Q3: combine the partial products.
  logic        q3_v_r;
  logic [63:0] q3_m_r, q3_pb_r, q3_s_r, q3_p_r;
  tag_t        q3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) q3_v_r <= 1'b0;
    else if (en) q3_v_r <= q2_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q3_m_r   <= 64'(sp9lo_r) + {sp9hi_r, 32'd0};
      q3_pb_r  <= 64'(pp8lo_r) + {pp8hi_r, 32'd0};
      q3_s_r   <= q2_s_r;
      q3_p_r   <= q2_p_r;
      q3_tag_r <= q2_tag_r;
    end
  end

  // Q4: low half of the 64x64 product m*s from three 32x32 products.
  logic [63:0] lh_w, hl_w;
  logic        q4_v_r;
  logic [63:0] ll_r, q4_pb_r, q4_p_r;
  logic [31:0] lh_r, hl_r;
  tag_t        q4_tag_r;

  assign lh_w = q3_m_r[31:0] * q3_s_r[63:32];
  assign hl_w = q3_m_r[63:32] * q3_s_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) q4_v_r <= 1'b0;
    else if (en) q4_v_r <= q3_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r     <= q3_m_r[31:0] * q3_s_r[31:0];
      lh_r     <= lh_w[31:0];
      hl_r     <= hl_w[31:0];
      q4_pb_r  <= q3_pb_r;
      q4_p_r   <= q3_p_r;
      q4_tag_r <= q3_tag_r;
    end
  end

  // Q5: the two correction terms.
  logic [63:0] msq_nxt;
  logic [31:0] mid_nxt;
  logic        q5_v_r;
  logic [63:0] a_r, b_r, q5_p_r;
  tag_t        q5_tag_r;

  assign mid_nxt = lh_r + hl_r;
  assign msq_nxt = ll_r + {mid_nxt, 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) q5_v_r <= 1'b0;
    else if (en) q5_v_r <= q4_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= $signed(msq_nxt) >>> 25;
      b_r      <= $signed(q4_pb_r) >>> 19;
      q5_p_r   <= q4_p_r;
      q5_tag_r <= q4_tag_r;
    end
  end

  // Output register.
  logic [63:0] sum_nxt;
  logic [31:0] pres_nxt;
  out_t        out_nxt;

  assign sum_nxt  = q5_p_r + a_r + b_r;
  assign pres_nxt = sum_nxt[39:8] + {{12{p7[15]}}, p7, 4'd0};

  // A zero divisor reports zero pressure, without the P7 offset.
  always_comb begin
    out_nxt.temperature_centi = q5_tag_r.tc;
    out_nxt.fine_temperature  = 32'(q5_tag_r.fine);
    out_nxt.pressure_pa_q24_8 = q5_tag_r.zero ? 32'd0 : pres_nxt;
    out_nxt.divisor_zero      = q5_tag_r.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= q5_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
